@@ rtl/core/hcmm_pkg.sv @@
// hcmm_pkg: shared types and constants for the handheld console memory map
// region, target and opcode codes, the memory request bundle, the i/o power-up table
// no dependencies
package hcmm_pkg;

   localparam int OFS_W         = 13;
   localparam int SPRITE_BYTES  = 160;
   localparam int IO_PAGE_BYTES = 256;
   localparam int OAM_AW        = 8;
   localparam int IO_AW         = 8;

   typedef logic [2:0] region_type;
   localparam region_type REG_ROM      = 3'd0;
   localparam region_type REG_VRAM     = 3'd1;
   localparam region_type REG_CRAM     = 3'd2;
   localparam region_type REG_WRAM     = 3'd3;
   localparam region_type REG_OAM      = 3'd4;
   localparam region_type REG_UNUSABLE = 3'd5;
   localparam region_type REG_IO       = 3'd6;

   typedef logic [2:0] target_type;
   localparam target_type TGT_INTERNAL = 3'd0;
   localparam target_type TGT_ROM      = 3'd1;
   localparam target_type TGT_CRAM     = 3'd2;
   localparam target_type TGT_JOYPAD   = 3'd3;
   localparam target_type TGT_GFX      = 3'd4;
   localparam target_type TGT_IGNORED  = 3'd5;

   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_READ  = 2'd0;
   localparam opcode_type OP_WRITE = 2'd1;
   localparam opcode_type OP_IRQ   = 2'd2;

   localparam logic [15:0] ADDR_ROM_END      = 16'h7FFF;
   localparam logic [15:0] ADDR_VRAM_END     = 16'h9FFF;
   localparam logic [15:0] ADDR_CRAM_END     = 16'hBFFF;
   localparam logic [15:0] ADDR_WRAM_END     = 16'hDFFF;
   localparam logic [15:0] ADDR_ECHO_END     = 16'hFDFF;
   localparam logic [15:0] ADDR_OAM_END      = 16'hFE9F;
   localparam logic [15:0] ADDR_UNUSABLE_END = 16'hFEFF;
   localparam logic [15:0] ADDR_JOYPAD       = 16'hFF00;
   localparam logic [15:0] ADDR_DIV          = 16'hFF04;
   localparam logic [15:0] ADDR_STAT         = 16'hFF41;
   localparam logic [15:0] ADDR_LY           = 16'hFF44;
   localparam logic [15:0] ADDR_DMA          = 16'hFF46;
   localparam logic [15:0] ADDR_BGP          = 16'hFF47;
   localparam logic [15:0] ADDR_OBP1         = 16'hFF49;
   localparam logic [15:0] ADDR_BCPS         = 16'hFF68;
   localparam logic [15:0] ADDR_OCPD         = 16'hFF6B;
   localparam logic [7:0]  IO_IF_OFS         = 8'h0F;

   typedef struct packed {
      logic             rd;
      logic             wr;
      region_type       region;
      logic [OFS_W-1:0] offset;
      logic [7:0]       wdata;
   } mem_req_type;

   localparam logic [7:0] IO_POWER_UP [IO_PAGE_BYTES] = '{
      8'h0F,8'h00,8'h7C,8'hFF,8'h00,8'h00,8'h00,8'hF8,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h01,
      8'h80,8'hBF,8'hF3,8'hFF,8'hBF,8'hFF,8'h3F,8'h00,
      8'hFF,8'hBF,8'h7F,8'hFF,8'h9F,8'hFF,8'hBF,8'hFF,
      8'hFF,8'h00,8'h00,8'hBF,8'h77,8'hF3,8'hF1,8'hFF,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'h00,8'hFF,8'h00,8'hFF,8'h00,8'hFF,8'h00,8'hFF,
      8'h00,8'hFF,8'h00,8'hFF,8'h00,8'hFF,8'h00,8'hFF,
      8'h91,8'h80,8'h00,8'h00,8'h00,8'h00,8'h00,8'hFC,
      8'h00,8'h00,8'h00,8'h00,8'hFF,8'h7E,8'hFF,8'hFE,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h3E,8'hFF,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hC0,8'hFF,8'hC1,8'h00,8'hFE,8'hFF,8'hFF,8'hFF,
      8'hF8,8'hFF,8'h00,8'h00,8'h00,8'h8F,8'h00,8'h00,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hCE,8'hED,8'h66,8'h66,8'hCC,8'h0D,8'h00,8'h0B,
      8'h03,8'h73,8'h00,8'h83,8'h00,8'h0C,8'h00,8'h0D,
      8'h00,8'h08,8'h11,8'h1F,8'h88,8'h89,8'h00,8'h0E,
      8'hDC,8'hCC,8'h6E,8'hE6,8'hDD,8'hDD,8'hD9,8'h99,
      8'hBB,8'hBB,8'h67,8'h63,8'h6E,8'h0E,8'hEC,8'hCC,
      8'hDD,8'hDC,8'h99,8'h9F,8'hBB,8'hB9,8'h33,8'h3E,
      8'h45,8'hEC,8'h52,8'hFA,8'h08,8'hB7,8'h07,8'h5D,
      8'h01,8'hFD,8'hC0,8'hFF,8'h08,8'hFC,8'h00,8'hE5,
      8'h0B,8'hF8,8'hC2,8'hCE,8'hF4,8'hF9,8'h0F,8'h7F,
      8'h45,8'h6D,8'h3D,8'hFE,8'h46,8'h97,8'h33,8'h5E,
      8'h08,8'hEF,8'hF1,8'hFF,8'h86,8'h83,8'h24,8'h74,
      8'h12,8'hFC,8'h00,8'h9F,8'hB4,8'hB7,8'h06,8'hD5,
      8'hD0,8'h7A,8'h00,8'h9E,8'h04,8'h5F,8'h41,8'h2F,
      8'h1D,8'h77,8'h36,8'h75,8'h81,8'hAA,8'h70,8'h3A,
      8'h98,8'hD1,8'h71,8'h02,8'h4D,8'h01,8'hC1,8'hFF,
      8'h0D,8'h00,8'hD3,8'h05,8'hF9,8'h00,8'h0B,8'h00
   };

endpackage

@@ rtl/core/handheld_console_memory_map_unit.sv @@
// handheld_console_memory_map_unit: top level of the handheld console memory map
// ties together hcmm_seq, hcmm_decode and hcmm_store; depends on hcmm_pkg
//
//   channel   ports                                        handshake
//   request   req_opcode, req_bus_address, req_write_data  start & !busy
//   response  rsp_read_data, rsp_target, rsp_forward_*,    rsp_strobe, one cycle
//             rsp_dma_skipped
//
// an internal read runs through the exec, wait and response states, an irq through
// exec, irq and response, other items but a dma through exec and response; busy drops
// when the sequencer is back in idle; the wait state is for the registered read data
// a dma write alternates a read and a write state per sprite byte, the read through
// the shared decoder; after reset busy stays high while video ram is swept to zero
// reset is synchronous; the receiver cannot stall, each result is strobed for exactly one cycle
module handheld_console_memory_map_unit import hcmm_pkg::*; #(
   parameter int WORK_RAM_BYTES  = 8192,
   parameter int VIDEO_RAM_BYTES = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_bus_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_read_data,
   output logic [2:0]  rsp_target,
   output logic [15:0] rsp_forward_address,
   output logic [7:0]  rsp_forward_data,
   output logic        rsp_dma_skipped
);

   logic [15:0] dec_addr;
   region_type  region;
   mem_req_type mem_req;
   logic [7:0]  rdata;
   logic        clearing;

   hcmm_seq u_seq (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_bus_address     (req_bus_address),
      .req_write_data      (req_write_data),
      .dec_addr            (dec_addr),
      .region              (region),
      .mem_req             (mem_req),
      .rdata               (rdata),
      .clearing            (clearing),
      .rsp_strobe          (rsp_strobe),
      .rsp_read_data       (rsp_read_data),
      .rsp_target          (rsp_target),
      .rsp_forward_address (rsp_forward_address),
      .rsp_forward_data    (rsp_forward_data),
      .rsp_dma_skipped     (rsp_dma_skipped)
   );

   hcmm_decode u_decode (
      .addr   (dec_addr),
      .region (region)
   );

   hcmm_store #(
      .WORK_RAM_BYTES  (WORK_RAM_BYTES),
      .VIDEO_RAM_BYTES (VIDEO_RAM_BYTES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .mem_req  (mem_req),
      .rdata    (rdata),
      .clearing (clearing)
   );

endmodule

@@ rtl/core/hcmm_decode.sv @@
// hcmm_decode: address region decoder shared by cpu accesses and dma source reads
// depends on hcmm_pkg
module hcmm_decode import hcmm_pkg::*; (
   input  logic [15:0] addr,
   output region_type  region
);

   always_comb begin
      if (addr <= ADDR_ROM_END) begin
         region = REG_ROM;
      end else if (addr <= ADDR_VRAM_END) begin
         region = REG_VRAM;
      end else if (addr <= ADDR_CRAM_END) begin
         region = REG_CRAM;
      end else if (addr <= ADDR_ECHO_END) begin
         // echo region folds onto work ram through the low 13 address bits
         region = REG_WRAM;
      end else if (addr <= ADDR_OAM_END) begin
         region = REG_OAM;
      end else if (addr <= ADDR_UNUSABLE_END) begin
         region = REG_UNUSABLE;
      end else begin
         region = REG_IO;
      end
   end

endmodule

@@ rtl/core/hcmm_store.sv @@
// hcmm_store: work ram, video ram, sprite table and i/o page with registered reads
// video ram clearing sweep after reset, valid bits for sprite table and i/o page
// depends on hcmm_pkg
module hcmm_store import hcmm_pkg::*; #(
   parameter int WORK_RAM_BYTES  = 8192,
   parameter int VIDEO_RAM_BYTES = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mem_req,
   output logic [7:0]  rdata,
   output logic        clearing
);

   localparam int WAW = $clog2(WORK_RAM_BYTES);
   localparam int VAW = $clog2(VIDEO_RAM_BYTES);

   logic [7:0] wram [WORK_RAM_BYTES];
   logic [7:0] vram [VIDEO_RAM_BYTES];
   logic [7:0] oam  [SPRITE_BYTES];
   logic [7:0] io   [IO_PAGE_BYTES];

   logic [SPRITE_BYTES-1:0]  oam_vld_ff;
   logic [IO_PAGE_BYTES-1:0] io_vld_ff;
   logic                     clr_ff;
   logic [VAW-1:0]           clr_cnt_ff;
   region_type               rd_region_ff;
   logic [7:0]               wram_q_ff;
   logic [7:0]               vram_q_ff;
   logic [7:0]               oam_q_ff;
   logic [7:0]               io_q_ff;
   logic                     oam_vld_q_ff;
   logic                     io_vld_q_ff;
   logic [IO_AW-1:0]         io_idx_q_ff;

   logic [WAW-1:0]    wram_idx;
   logic [VAW-1:0]    vram_idx;
   logic [OAM_AW-1:0] oam_idx;
   logic [IO_AW-1:0]  io_idx;
   logic              wram_sel;
   logic              vram_sel;
   logic              oam_sel;
   logic              io_sel;

   assign wram_idx = WAW'(mem_req.offset);
   assign vram_idx = VAW'(mem_req.offset);
   assign oam_idx  = mem_req.offset[OAM_AW-1:0];
   assign io_idx   = mem_req.offset[IO_AW-1:0];
   assign wram_sel = (mem_req.region == REG_WRAM);
   assign vram_sel = (mem_req.region == REG_VRAM);
   assign oam_sel  = (mem_req.region == REG_OAM);
   assign io_sel   = (mem_req.region == REG_IO);
   assign clearing = clr_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr && wram_sel) begin
         wram[wram_idx] <= mem_req.wdata;
      end
      if (mem_req.rd && wram_sel) begin
         wram_q_ff <= wram[wram_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         vram[clr_cnt_ff] <= 8'h00;
      end else if (mem_req.wr && vram_sel) begin
         vram[vram_idx] <= mem_req.wdata;
      end
      if (mem_req.rd && vram_sel) begin
         vram_q_ff <= vram[vram_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr && oam_sel) begin
         oam[oam_idx] <= mem_req.wdata;
      end
      if (mem_req.rd && oam_sel) begin
         oam_q_ff     <= oam[oam_idx];
         oam_vld_q_ff <= oam_vld_ff[oam_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr && io_sel) begin
         io[io_idx] <= mem_req.wdata;
      end
      if (mem_req.rd && io_sel) begin
         io_q_ff     <= io[io_idx];
         io_vld_q_ff <= io_vld_ff[io_idx];
         io_idx_q_ff <= io_idx;
      end
   end

   // control state: clearing sweep, valid bits, region of the last read
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_cnt_ff   <= '0;
         oam_vld_ff   <= '0;
         io_vld_ff    <= '0;
         rd_region_ff <= REG_UNUSABLE;
      end else begin
         if (clr_ff) begin
            if (clr_cnt_ff == VAW'(VIDEO_RAM_BYTES - 1)) begin
               clr_ff <= 1'b0;
            end
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (mem_req.wr && oam_sel) begin
            oam_vld_ff[oam_idx] <= 1'b1;
         end
         if (mem_req.wr && io_sel) begin
            io_vld_ff[io_idx] <= 1'b1;
         end
         if (mem_req.rd) begin
            rd_region_ff <= mem_req.region;
         end
      end
   end

   always_comb begin
      case (rd_region_ff)
         REG_WRAM: rdata = wram_q_ff;
         REG_VRAM: rdata = vram_q_ff;
         REG_OAM:  rdata = oam_vld_q_ff ? oam_q_ff : 8'h00;
         REG_IO:   rdata = io_vld_q_ff ? io_q_ff : IO_POWER_UP[io_idx_q_ff];
         default:  rdata = 8'h00;
      endcase
   end

endmodule

@@ rtl/core/hcmm_seq.sv @@
// hcmm_seq: sequencer that runs one item through the decoder and the stores
// handles forwarding, read-modify-write for interrupt requests and the sprite dma loop
// depends on hcmm_pkg
module hcmm_seq import hcmm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_opcode,
   input  logic [15:0]       req_bus_address,
   input  logic [7:0]        req_write_data,
   output logic [15:0]       dec_addr,
   input  region_type        region,
   output mem_req_type       mem_req,
   input  logic [7:0]        rdata,
   input  logic              clearing,
   output logic              rsp_strobe,
   output logic [7:0]        rsp_read_data,
   output logic [2:0]        rsp_target,
   output logic [15:0]       rsp_forward_address,
   output logic [7:0]        rsp_forward_data,
   output logic              rsp_dma_skipped
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_WAIT   = 3'd2;
   localparam logic [2:0] S_IRQ    = 3'd3;
   localparam logic [2:0] S_DMA_RD = 3'd4;
   localparam logic [2:0] S_DMA_WR = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0]        state_ff, state_in;
   opcode_type        op_ff, op_in;
   logic [15:0]       addr_ff, addr_in;
   logic [7:0]        wdata_ff, wdata_in;
   logic [OAM_AW-1:0] cnt_ff, cnt_in;
   logic [7:0]        rd_ff, rd_in;
   target_type        tgt_ff, tgt_in;
   logic [15:0]       fa_ff, fa_in;
   logic [7:0]        fd_ff, fd_in;
   logic              skip_ff, skip_in;

   logic accept;
   logic is_gfx;
   logic cart_page;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE) || clearing;
   assign dec_addr  = (state_ff == S_DMA_RD) ? {wdata_ff, cnt_ff} : addr_ff;
   assign is_gfx    = (addr_ff == ADDR_STAT)
                   || (addr_ff >= ADDR_BGP && addr_ff <= ADDR_OBP1)
                   || (addr_ff >= ADDR_BCPS && addr_ff <= ADDR_OCPD);
   // source pages in cartridge rom or cartridge ram
   assign cart_page = !wdata_ff[7] || (wdata_ff[7:5] == 3'b101);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      addr_in  = addr_ff;
      wdata_in = wdata_ff;
      cnt_in   = cnt_ff;
      rd_in    = rd_ff;
      tgt_in   = tgt_ff;
      fa_in    = fa_ff;
      fd_in    = fd_ff;
      skip_in  = skip_ff;
      mem_req  = '0;
      mem_req.region = region;
      mem_req.offset = dec_addr[OFS_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               addr_in  = req_bus_address;
               wdata_in = req_write_data;
               rd_in    = 8'h00;
               tgt_in   = TGT_INTERNAL;
               fa_in    = 16'h0000;
               fd_in    = 8'h00;
               skip_in  = 1'b0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            case (op_ff)
               OP_READ: begin
                  case (region)
                     REG_ROM: begin
                        tgt_in = TGT_ROM;
                        fa_in  = addr_ff;
                     end
                     REG_CRAM: begin
                        tgt_in = TGT_CRAM;
                        fa_in  = addr_ff;
                     end
                     REG_UNUSABLE: tgt_in = TGT_IGNORED;
                     default: begin
                        mem_req.rd = 1'b1;
                        state_in   = S_WAIT;
                     end
                  endcase
               end
               OP_WRITE: begin
                  mem_req.wdata = wdata_ff;
                  case (region)
                     REG_ROM: begin
                        tgt_in = TGT_ROM;
                        fa_in  = addr_ff;
                        fd_in  = wdata_ff;
                     end
                     REG_CRAM: begin
                        tgt_in = TGT_CRAM;
                        fa_in  = addr_ff;
                        fd_in  = wdata_ff;
                     end
                     REG_UNUSABLE: tgt_in = TGT_IGNORED;
                     REG_IO: begin
                        if (addr_ff == ADDR_JOYPAD) begin
                           tgt_in = TGT_JOYPAD;
                           fa_in  = addr_ff;
                           fd_in  = wdata_ff;
                        end else if (is_gfx) begin
                           tgt_in = TGT_GFX;
                           fa_in  = addr_ff;
                           fd_in  = wdata_ff;
                        end else if (addr_ff == ADDR_DIV || addr_ff == ADDR_LY) begin
                           mem_req.wr    = 1'b1;
                           mem_req.wdata = 8'h00;
                        end else if (addr_ff == ADDR_DMA) begin
                           if (cart_page) begin
                              skip_in = 1'b1;
                           end else begin
                              cnt_in   = '0;
                              state_in = S_DMA_RD;
                           end
                        end else begin
                           mem_req.wr = 1'b1;
                        end
                     end
                     default: mem_req.wr = 1'b1;
                  endcase
               end
               OP_IRQ: begin
                  mem_req.rd     = 1'b1;
                  mem_req.region = REG_IO;
                  mem_req.offset = OFS_W'(IO_IF_OFS);
                  state_in       = S_IRQ;
               end
               default: tgt_in = TGT_IGNORED;
            endcase
         end
         S_WAIT: begin
            rd_in    = rdata;
            state_in = S_RESP;
         end
         S_IRQ: begin
            mem_req.wr     = 1'b1;
            mem_req.region = REG_IO;
            mem_req.offset = OFS_W'(IO_IF_OFS);
            mem_req.wdata  = rdata | wdata_ff;
            state_in       = S_RESP;
         end
         S_DMA_RD: begin
            mem_req.rd = 1'b1;
            state_in   = S_DMA_WR;
         end
         S_DMA_WR: begin
            mem_req.wr     = 1'b1;
            mem_req.region = REG_OAM;
            mem_req.offset = OFS_W'(cnt_ff);
            mem_req.wdata  = rdata;
            if (cnt_ff == OAM_AW'(SPRITE_BYTES - 1)) begin
               state_in = S_RESP;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_DMA_RD;
            end
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      addr_ff  <= addr_in;
      wdata_ff <= wdata_in;
      cnt_ff   <= cnt_in;
      rd_ff    <= rd_in;
      tgt_ff   <= tgt_in;
      fa_ff    <= fa_in;
      fd_ff    <= fd_in;
      skip_ff  <= skip_in;
   end

   assign rsp_strobe          = (state_ff == S_RESP);
   assign rsp_read_data       = rd_ff;
   assign rsp_target          = tgt_ff;
   assign rsp_forward_address = fa_ff;
   assign rsp_forward_data    = fd_ff;
   assign rsp_dma_skipped     = skip_ff;

endmodule
